// ===== rtl/lvc_pkg.sv =====
// Shared types, constants and CRC column table for the lattice vector checksum.
package lvc_pkg;

    // Default geometry and stream shape
    localparam int unsigned WORDS_PER_SITE_DEF = 6;
    localparam int unsigned LAT_X_DEF          = 64;
    localparam int unsigned LAT_Y_DEF          = 64;
    localparam int unsigned LAT_Z_DEF          = 64;

    // Field widths
    localparam int unsigned SIZE_W   = 9;
    localparam int unsigned ORG_W    = 8;
    localparam int unsigned COORD_W  = 8;
    localparam int unsigned GIDX_W   = 26;
    localparam int unsigned CFG_IX_W = 3;

    // CRC32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Rotation moduli and their scaled reciprocals (2^16 / m, rounded up)
    localparam int unsigned MOD_A   = 29;
    localparam int unsigned MOD_B   = 31;
    localparam int unsigned RECIP_A = (2**16 + MOD_A - 1) / MOD_A;
    localparam int unsigned RECIP_B = (2**16 + MOD_B - 1) / MOD_B;

    typedef struct packed {
        logic        command;
        logic [63:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0]       sum_a;
        logic [31:0]       sum_b;
        logic [31:0]       crc_out;
        logic [GIDX_W-1:0] index_out;
    } t_out_item;

    typedef struct packed {
        logic [SIZE_W-1:0] local_size_x;
        logic [SIZE_W-1:0] local_size_y;
        logic [SIZE_W-1:0] local_size_z;
        logic [SIZE_W-1:0] local_size_t;
        logic [ORG_W-1:0]  origin_x;
        logic [ORG_W-1:0]  origin_y;
        logic [ORG_W-1:0]  origin_z;
        logic [ORG_W-1:0]  origin_t;
    } t_cfg;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_SIZE_X   = 3'd0,
        CFG_SIZE_Y   = 3'd1,
        CFG_SIZE_Z   = 3'd2,
        CFG_SIZE_T   = 3'd3,
        CFG_ORIGIN_X = 3'd4,
        CFG_ORIGIN_Y = 3'd5,
        CFG_ORIGIN_Z = 3'd6,
        CFG_ORIGIN_T = 3'd7
    } t_cfg_reg;

    // Index sequencer states; each one also names the datapath step taken in it
    typedef enum logic [2:0] {
        IX_LOAD,
        IX_STEP_Z,
        IX_STEP_Y,
        IX_STEP_X,
        IX_READY
    } t_ix_state;

    typedef struct packed {
        t_ix_state ix_step;
        logic      word_acc;
        logic      clear_acc;
        logic      site_done;
    } t_dp_cmd;

    typedef struct packed {
        logic last_word;
        logic out_free;
    } t_dp_sts;

    // One column per input bit of the 64-bit CRC update: bits 31:0 state, 95:32 data
    typedef logic [95:0][31:0] t_crc_cols;

    function automatic t_crc_cols crc_columns();
        t_crc_cols   cols;
        logic [95:0] v;
        logic [31:0] c;
        logic [63:0] w;
        for (int j = 0; j < 96; j++) begin
            v = 96'(1) << j;
            c = v[31:0];
            w = v[95:32];
            for (int k = 0; k < 8; k++) begin
                c = c ^ {24'h0, w[8*k +: 8]};
                for (int b = 0; b < 8; b++) begin
                    c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
                end
            end
            cols[j] = c;
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = crc_columns();

endpackage

// ===== rtl/lvc_ctrl.sv =====
// Controller: index sequencer state machine and input acceptance.
module lvc_ctrl
    import lvc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_command,
    input  logic    i_cfg_we,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_ix_state r_state;
    t_ix_state n_state;
    logic      w_ready;
    logic      w_acc;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IX_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Accept, command decode and sequencing
    always_comb begin
        // hold the completing word until the index is known and the result slot is free
        w_ready = !i_sts.last_word || ((r_state == IX_READY) && i_sts.out_free);
        w_acc   = i_in_valid && w_ready;

        o_cmd.ix_step   = r_state;
        o_cmd.word_acc  = w_acc && !i_in_command;
        o_cmd.clear_acc = w_acc && i_in_command;
        o_cmd.site_done = w_acc && !i_in_command && i_sts.last_word;

        case (r_state)
            IX_LOAD:   n_state = IX_STEP_Z;
            IX_STEP_Z: n_state = IX_STEP_Y;
            IX_STEP_Y: n_state = IX_STEP_X;
            IX_STEP_X: n_state = IX_READY;
            IX_READY:  n_state = IX_READY;
            default:   n_state = IX_LOAD;
        endcase

        // restart whenever the coordinates or origins may have moved
        if (i_cfg_we || o_cmd.clear_acc || o_cmd.site_done) begin
            n_state = IX_LOAD;
        end
    end

    assign o_in_ready = w_ready;

endmodule

// ===== rtl/lvc_datapath.sv =====
// Datapath: CRC update, site counters, index multiply-add, rotated sums, result register.
module lvc_datapath
    import lvc_pkg::*;
#(
    parameter int unsigned WORDS_PER_SITE = WORDS_PER_SITE_DEF,
    parameter int unsigned LAT_X          = LAT_X_DEF,
    parameter int unsigned LAT_Y          = LAT_Y_DEF,
    parameter int unsigned LAT_Z          = LAT_Z_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_in_item,
    input  logic      i_out_ready,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int unsigned WCW = (WORDS_PER_SITE > 1) ? $clog2(WORDS_PER_SITE) : 1;
    localparam logic [WCW-1:0] LAST_WORD = WCW'(WORDS_PER_SITE - 1);

    localparam logic [SIZE_W-1:0] LX = SIZE_W'(LAT_X);
    localparam logic [SIZE_W-1:0] LY = SIZE_W'(LAT_Y);
    localparam logic [SIZE_W-1:0] LZ = SIZE_W'(LAT_Z);
    localparam logic [4:0] LX_A = 5'(LAT_X % MOD_A);
    localparam logic [4:0] LY_A = 5'(LAT_Y % MOD_A);
    localparam logic [4:0] LZ_A = 5'(LAT_Z % MOD_A);
    localparam logic [4:0] LX_B = 5'(LAT_X % MOD_B);
    localparam logic [4:0] LY_B = 5'(LAT_Y % MOD_B);
    localparam logic [4:0] LZ_B = 5'(LAT_Z % MOD_B);

    // Reduce a value below 64 times the modulus by a small modulus via its scaled reciprocal
    function automatic logic [4:0] red_mod(input logic [10:0] v, input logic [4:0] m,
                                           input logic [11:0] recip);
        logic [22:0] p;
        logic [10:0] r;
        p = 23'(v) * 23'(recip);
        r = v - 11'(p[21:16]) * 11'(m);
        if (r >= 11'(m)) begin
            r = r - 11'(m);
        end
        return r[4:0];
    endfunction

    // Size zero acts as one, anything above 256 as 256
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        if (s == '0) begin
            return SIZE_W'(1);
        end else if (s[SIZE_W-1] && (s[SIZE_W-2:0] != '0)) begin
            return SIZE_W'(256);
        end
        return s;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] r);
        logic [63:0] t;
        t = {v, v} << r;
        return t[63:32];
    endfunction

    logic [31:0]        r_crc;
    logic [WCW-1:0]     r_word_count;
    logic [COORD_W-1:0] r_x, r_y, r_z, r_t;
    logic [31:0]        r_hash_a, r_hash_b;
    logic [GIDX_W-1:0]  r_acc;
    logic [4:0]         r_res_a, r_res_b;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic [31:0]        n_crc;
    logic [31:0]        n_hash_a, n_hash_b;
    logic [GIDX_W-1:0]  n_acc;
    logic [4:0]         n_res_a, n_res_b;
    logic [COORD_W-1:0] n_x, n_y, n_z, n_t;

    logic [95:0]        w_crc_in;
    logic [31:0]        w_site_crc;
    logic [SIZE_W-1:0]  w_sum_x, w_sum_y, w_sum_z, w_sum_t;
    logic [SIZE_W-1:0]  w_csum, w_lat;
    logic [4:0]         w_lat_a, w_lat_b;
    logic [34:0]        w_prod;
    logic [10:0]        w_mix_a, w_mix_b;
    logic [SIZE_W-1:0]  w_inc_x, w_inc_y, w_inc_z, w_inc_t;
    logic               w_wrap_x, w_wrap_y, w_wrap_z, w_wrap_t;

    // 64-bit CRC update as an XOR of constant columns
    assign w_crc_in = {i_in_item.data_word, r_crc};

    always_comb begin
        n_crc = '0;
        for (int j = 0; j < 96; j++) begin
            if (w_crc_in[j]) begin
                n_crc = n_crc ^ CRC_COLS[j];
            end
        end
    end

    assign w_site_crc = n_crc ^ CRC_INIT;
    assign n_hash_a   = r_hash_a ^ rotl(w_site_crc, r_res_a);
    assign n_hash_b   = r_hash_b ^ rotl(w_site_crc, r_res_b);

    // Global coordinates of the current site
    assign w_sum_x = {1'b0, r_x} + {1'b0, i_cfg.origin_x};
    assign w_sum_y = {1'b0, r_y} + {1'b0, i_cfg.origin_y};
    assign w_sum_z = {1'b0, r_z} + {1'b0, i_cfg.origin_z};
    assign w_sum_t = {1'b0, r_t} + {1'b0, i_cfg.origin_t};

    // Select the axis for this sequencer step; load uses a zero stride
    always_comb begin
        case (i_cmd.ix_step)
            IX_STEP_Z: begin
                w_lat = LZ; w_lat_a = LZ_A; w_lat_b = LZ_B; w_csum = w_sum_z;
            end
            IX_STEP_Y: begin
                w_lat = LY; w_lat_a = LY_A; w_lat_b = LY_B; w_csum = w_sum_y;
            end
            IX_STEP_X: begin
                w_lat = LX; w_lat_a = LX_A; w_lat_b = LX_B; w_csum = w_sum_x;
            end
            default: begin
                w_lat = '0; w_lat_a = '0; w_lat_b = '0; w_csum = w_sum_t;
            end
        endcase
    end

    // Horner step on the index and on both residues
    assign w_prod  = 35'(r_acc) * 35'(w_lat);
    assign n_acc   = w_prod[GIDX_W-1:0] + GIDX_W'(w_csum);
    assign w_mix_a = 11'(r_res_a) * 11'(w_lat_a) + 11'(w_csum);
    assign w_mix_b = 11'(r_res_b) * 11'(w_lat_b) + 11'(w_csum);
    assign n_res_a = red_mod(w_mix_a, 5'(MOD_A), 12'(RECIP_A));
    assign n_res_b = red_mod(w_mix_b, 5'(MOD_B), 12'(RECIP_B));

    // Site coordinate stepping, x fastest, t wraps without carry
    always_comb begin
        w_inc_x  = {1'b0, r_x} + SIZE_W'(1);
        w_inc_y  = {1'b0, r_y} + SIZE_W'(1);
        w_inc_z  = {1'b0, r_z} + SIZE_W'(1);
        w_inc_t  = {1'b0, r_t} + SIZE_W'(1);
        w_wrap_x = w_inc_x >= eff_size(i_cfg.local_size_x);
        w_wrap_y = w_inc_y >= eff_size(i_cfg.local_size_y);
        w_wrap_z = w_inc_z >= eff_size(i_cfg.local_size_z);
        w_wrap_t = w_inc_t >= eff_size(i_cfg.local_size_t);
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_t = r_t;
        n_x = w_wrap_x ? '0 : w_inc_x[COORD_W-1:0];
        if (w_wrap_x) begin
            n_y = w_wrap_y ? '0 : w_inc_y[COORD_W-1:0];
            if (w_wrap_y) begin
                n_z = w_wrap_z ? '0 : w_inc_z[COORD_W-1:0];
                if (w_wrap_z) begin
                    n_t = w_wrap_t ? '0 : w_inc_t[COORD_W-1:0];
                end
            end
        end
    end

    // Running CRC, counters and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= CRC_INIT;
            r_word_count <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_z          <= '0;
            r_t          <= '0;
            r_hash_a     <= '0;
            r_hash_b     <= '0;
        end else if (i_cmd.clear_acc) begin
            r_crc        <= CRC_INIT;
            r_word_count <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_z          <= '0;
            r_t          <= '0;
            r_hash_a     <= '0;
            r_hash_b     <= '0;
        end else if (i_cmd.site_done) begin
            r_crc        <= CRC_INIT;
            r_word_count <= '0;
            r_x          <= n_x;
            r_y          <= n_y;
            r_z          <= n_z;
            r_t          <= n_t;
            r_hash_a     <= n_hash_a;
            r_hash_b     <= n_hash_b;
        end else if (i_cmd.word_acc) begin
            r_crc        <= n_crc;
            r_word_count <= r_word_count + WCW'(1);
        end
    end

    // Index accumulator; clear at reset so the first sequence starts from known values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_res_a <= '0;
            r_res_b <= '0;
        end else if (i_cmd.ix_step != IX_READY) begin
            r_acc   <= n_acc;
            r_res_a <= n_res_a;
            r_res_b <= n_res_b;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.site_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.site_done) begin
            r_out_item.sum_a     <= n_hash_a;
            r_out_item.sum_b     <= n_hash_b;
            r_out_item.crc_out   <= w_site_crc;
            r_out_item.index_out <= r_acc;
        end
    end

    assign o_sts.last_word = (r_word_count == LAST_WORD);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;

endmodule

// ===== rtl/lattice_vector_checksum.sv =====
// Top level of the lattice vector checksum: configuration registers and unit wiring.
//
// Takes 64-bit file words, WORDS_PER_SITE to a site, and gives one item per completed
// site: the site's CRC32, its global index (low 26 bits) and the two running XOR sums of
// the CRC rotated left by the index mod 29 and mod 31. A clear item (command set) resets
// the CRC, the word and site counters and both sums, and gives no result. Words are taken
// one per cycle except when the completing word is held. The global index is built by a
// four-step multiply-add sequencer that restarts after each completed site, after a clear
// and after any configuration write; the word that completes a site waits until that
// sequence has finished and the result register is free. Configuration writes are taken in
// any cycle and belong in periods with no site in progress.
module lattice_vector_checksum
    import lvc_pkg::*;
#(
    parameter int unsigned WORDS_PER_SITE = WORDS_PER_SITE_DEF,
    parameter int unsigned LAT_X          = LAT_X_DEF,
    parameter int unsigned LAT_Y          = LAT_Y_DEF,
    parameter int unsigned LAT_Z          = LAT_Z_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_item,
    input  logic                i_cfg_we,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]   i_cfg_wdata
);

    t_cfg    r_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_size_x <= SIZE_W'(1);
            r_cfg.local_size_y <= SIZE_W'(1);
            r_cfg.local_size_z <= SIZE_W'(1);
            r_cfg.local_size_t <= SIZE_W'(1);
            r_cfg.origin_x     <= '0;
            r_cfg.origin_y     <= '0;
            r_cfg.origin_z     <= '0;
            r_cfg.origin_t     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SIZE_X:   r_cfg.local_size_x <= i_cfg_wdata;
                CFG_SIZE_Y:   r_cfg.local_size_y <= i_cfg_wdata;
                CFG_SIZE_Z:   r_cfg.local_size_z <= i_cfg_wdata;
                CFG_SIZE_T:   r_cfg.local_size_t <= i_cfg_wdata;
                CFG_ORIGIN_X: r_cfg.origin_x     <= i_cfg_wdata[ORG_W-1:0];
                CFG_ORIGIN_Y: r_cfg.origin_y     <= i_cfg_wdata[ORG_W-1:0];
                CFG_ORIGIN_Z: r_cfg.origin_z     <= i_cfg_wdata[ORG_W-1:0];
                CFG_ORIGIN_T: r_cfg.origin_t     <= i_cfg_wdata[ORG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lvc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_command (i_in_item.command),
        .i_cfg_we     (i_cfg_we),
        .i_sts        (w_sts),
        .o_in_ready   (o_in_ready),
        .o_cmd        (w_cmd)
    );

    lvc_datapath #(
        .WORDS_PER_SITE (WORDS_PER_SITE),
        .LAT_X          (LAT_X),
        .LAT_Y          (LAT_Y),
        .LAT_Z          (LAT_Z)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // A new result appears only after a data word completed a site
    a_result_from_site: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && !i_in_item.command))
        else $error("result raised without a completing word");

    // The completing word is never taken while the result register is still occupied
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && w_sts.last_word) |-> w_sts.out_free)
        else $error("completing word accepted over a pending result");

    // After a clear the index sequence restarts, so no site can complete next cycle
    a_clear_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear_acc |=> !w_cmd.site_done)
        else $error("site completed straight after a clear");

endmodule
